[sv/bvac_pkg.sv]
// ----------------------------------------------------------------------------
// bvac_pkg
// Shared constants and types for the byte Vigenere autokey cipher block.
// ----------------------------------------------------------------------------
package bvac_pkg;

  // Key store geometry.
  localparam int KEY_MAX   = 32;
  localparam int POS_W     = $clog2(KEY_MAX);
  localparam int LEN_W     = POS_W + 1;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int KEY_WORDS = 4;

  // Mode register bit meanings.
  localparam int MODE_AUTO_BIT = 0;
  localparam int MODE_DEC_BIT  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES3 = 3'd5;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]                         mode;
    logic [LEN_W-1:0]                   eff_len;
    logic [KEY_MAX-1:0][BYTE_W-1:0]     key;
  } cfg_t;

endpackage

[sv/byte_vigenere_autokey_cipher.sv]
// Input beats are registered, then computed into the output register.
// Throughput: one byte per cycle unless the output stalls; the key position,
// first pass flag and the 32-entry plaintext ring all update in the single
// compute stage. Reset (rst_n low, synchronous): pipeline empties, key
// position goes to 0, first pass is set, registers take their reset values.
// The ring is not cleared; under a steady configuration it is only read once written in a message.
// ----------------------------------------------------------------------------
// byte_vigenere_autokey_cipher
// Byte stream Vigenere cipher modulo 256 with repeating-key and autokey modes.
// ----------------------------------------------------------------------------
module byte_vigenere_autokey_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bvac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bvac_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bvac_pkg::BYTE_W-1:0]       in_byte,
  input  logic                              in_first_of_message,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bvac_pkg::BYTE_W-1:0]       out_byte
);
  import bvac_pkg::*;

  cfg_t                          cfg;

  logic                          s1_vld_r;
  logic [BYTE_W-1:0]             s1_byte_r;
  logic                          s1_first_r;
  logic                          out_vld_r;
  logic [BYTE_W-1:0]             out_byte_r;
  logic [POS_W-1:0]              key_pos_r;
  logic                          first_pass_r;
  logic [KEY_MAX-1:0][BYTE_W-1:0] hist_r;

  logic                          s1_adv;
  logic                          autokey;
  logic                          decrypt;
  logic [POS_W-1:0]              pos_cur;
  logic                          fp_cur;
  logic [BYTE_W-1:0]             key_k;
  logic [BYTE_W-1:0]             y;
  logic [BYTE_W-1:0]             plain;
  logic [LEN_W-1:0]              pos_inc;
  logic                          wrap;

  bvac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the compute stage moves whenever the output register frees.
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_byte;
      s1_first_r <= in_first_of_message;
    end
  end

  // Key selection and the modulo-256 add or subtract.
  always_comb begin
    autokey = cfg.mode[MODE_AUTO_BIT];
    decrypt = cfg.mode[MODE_DEC_BIT];
    pos_cur = s1_first_r ? '0 : key_pos_r;
    fp_cur  = s1_first_r ? 1'b1 : first_pass_r;
    if (autokey && !fp_cur) begin
      key_k = hist_r[pos_cur];
    end else begin
      key_k = cfg.key[pos_cur];
    end
    y       = decrypt ? (s1_byte_r - key_k) : (s1_byte_r + key_k);
    plain   = decrypt ? y : s1_byte_r;
    pos_inc = {1'b0, pos_cur} + LEN_W'(1);
    wrap    = (pos_inc >= cfg.eff_len);
  end

  // Key position, first pass flag and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r    <= '0;
      first_pass_r <= 1'b1;
      out_vld_r    <= 1'b0;
    end else begin
      if (s1_adv) begin
        key_pos_r    <= wrap ? '0 : pos_inc[POS_W-1:0];
        first_pass_r <= (wrap && autokey) ? 1'b0 : fp_cur;
        out_vld_r    <= 1'b1;
      end else if (out_ready) begin
        out_vld_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= y;
    end
  end

  // Plaintext ring, written only in autokey modes.
  always_ff @(posedge clk) begin
    if (s1_adv && autokey) begin
      hist_r[pos_cur] <= plain;
    end
  end

  assign out_valid = out_vld_r;
  assign out_byte  = out_byte_r;

endmodule

[sv/bvac_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bvac_cfg_regs
// Configuration register file: mode, clamped key length and the key bytes.
// ----------------------------------------------------------------------------
module bvac_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bvac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bvac_pkg::CFG_DAT_W-1:0]    cfg_data,
  output bvac_pkg::cfg_t                    cfg
);
  import bvac_pkg::*;

  logic [1:0]                            mode_r;
  logic [LEN_W-1:0]                      eff_len_r;
  logic [KEY_WORDS-1:0][CFG_DAT_W-1:0]   key_r;
  logic [LEN_W-1:0]                      len_in;
  logic                                  wr_en;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  // Clamp the key length into 1..KEY_MAX as it is written.
  always_comb begin
    len_in = cfg_data[LEN_W-1:0];
    if (len_in == '0) begin
      len_in = LEN_W'(1);
    end else if (len_in > LEN_W'(KEY_MAX)) begin
      len_in = LEN_W'(KEY_MAX);
    end
  end

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      eff_len_r <= LEN_W'(1);
      key_r     <= '0;
    end else if (wr_en) begin
      case (cfg_index)
        CFG_MODE:       mode_r    <= cfg_data[1:0];
        CFG_KEY_LENGTH: eff_len_r <= len_in;
        CFG_KEY_BYTES0: key_r[0]  <= cfg_data;
        CFG_KEY_BYTES1: key_r[1]  <= cfg_data;
        CFG_KEY_BYTES2: key_r[2]  <= cfg_data;
        CFG_KEY_BYTES3: key_r[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.mode    = mode_r;
  assign cfg.eff_len = eff_len_r;
  assign cfg.key     = key_r;

endmodule

[sv/bvac_checker.sv]
// ----------------------------------------------------------------------------
// bvac_checker
// Port-level checks for the cipher block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bvac_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bvac_pkg::BYTE_W-1:0]    out_byte
);
  import bvac_pkg::*;

  // A stalled output beat keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output beat changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // With the sink ready, the block never refuses input.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // An accepted beat reaches the output if the sink is ready while the beat sits in the input register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind byte_vigenere_autokey_cipher bvac_checker u_bvac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte Vigenere autokey cipher. Bytes go in over
// the input channel with random gaps and output stalls. A local copy of the
// cipher state predicts every output byte, and a checker compares each output
// beat with the oldest prediction. Directed tests cover reset values, length
// extremes and both autokey directions, then random messages follow.
// ----------------------------------------------------------------------------
module tb_top;
  import bvac_pkg::*;

  // Mode register values.
  localparam logic [1:0] MODE_ENC_REPEAT = 2'd0;
  localparam logic [1:0] MODE_ENC_AUTO   = 2'd1;
  localparam logic [1:0] MODE_DEC_REPEAT = 2'd2;
  localparam logic [1:0] MODE_DEC_AUTO   = 2'd3;

  localparam int NUM_REGS      = int'(CFG_KEY_BYTES3) + 1;
  localparam int KEY_BITS      = KEY_MAX * BYTE_W;
  localparam int RANDOM_BYTES  = 1350;
  localparam int REPORT_MAX    = 10;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    int                seq;
  } cipher_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_byte;
  logic                 in_first_of_message;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_W-1:0]    out_byte;

  // Local copy of the cipher registers and state.
  logic [1:0]          cur_mode;
  logic [5:0]          cur_key_length;
  logic [KEY_BITS-1:0] cur_key;
  logic [POS_W-1:0]    key_pos;
  logic                first_pass;
  logic [BYTE_W-1:0]   plain_ring [KEY_MAX];
  bit                  ring_written [KEY_MAX];

  cipher_beat_t expected_bytes[$];
  int           bytes_sent;
  int           mismatch_count;
  bit           sender_gaps;
  bit           quiet_tail;

  byte_vigenere_autokey_cipher dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .in_first_of_message (in_first_of_message),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("** byte_vigenere_autokey_cipher: FAILED **");
    $finish;
  end

  // Computes the output byte for one input byte and advances the local state.
  function automatic logic [BYTE_W-1:0] predict_cipher_byte(input logic [BYTE_W-1:0] x,
                                                            input logic restart);
    logic              decrypt;
    logic              autokey;
    logic [BYTE_W-1:0] k;
    logic [BYTE_W-1:0] y;
    int                len;
    int                nxt;
    decrypt = cur_mode[MODE_DEC_BIT];
    autokey = cur_mode[MODE_AUTO_BIT];
    // A zero length acts as one and anything above the store size saturates.
    if (cur_key_length == 0) len = 1;
    else if (cur_key_length > KEY_MAX) len = KEY_MAX;
    else len = int'(cur_key_length);
    if (restart) begin
      key_pos    = '0;
      first_pass = 1'b1;
    end
    if (autokey && !first_pass) k = plain_ring[key_pos];
    else k = cur_key[key_pos*BYTE_W +: BYTE_W];
    y = decrypt ? x - k : x + k;
    // Autokey modes remember the plaintext side of every byte.
    if (autokey) begin
      plain_ring[key_pos]   = decrypt ? y : x;
      ring_written[key_pos] = 1'b1;
    end
    nxt = int'(key_pos) + 1;
    if (nxt >= len) begin
      nxt = 0;
      if (autokey) first_pass = 1'b0;
    end
    key_pos = nxt[POS_W-1:0];
    return y;
  endfunction

  // Stops the input side and waits until every predicted byte has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the registers selected in reg_mask, in index order, on an idle block.
  task automatic configure(input logic [1:0] mode, input logic [5:0] klen,
                           input logic [KEY_BITS-1:0] key, input logic [NUM_REGS-1:0] reg_mask);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    int                   word;
    drain_results();
    for (int i = 0; i < NUM_REGS; i++) begin
      if (reg_mask[i]) begin
        idx  = i[CFG_IDX_W-1:0];
        data = {$urandom(), $urandom()};
        word = i - int'(CFG_KEY_BYTES0);
        case (idx)
          CFG_MODE: begin
            data[1:0] = mode;
          end
          CFG_KEY_LENGTH: begin
            data[5:0] = klen;
          end
          default: begin
            data = key[word*CFG_DAT_W +: CFG_DAT_W];
          end
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        // Only the low bits of the mode and length beats are meaningful.
        case (idx)
          CFG_MODE:       cur_mode = data[1:0];
          CFG_KEY_LENGTH: cur_key_length = data[5:0];
          default:        cur_key[word*CFG_DAT_W +: CFG_DAT_W] = data;
        endcase
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Sends one byte and records its predicted output. Leaves valid high so that
  // a following beat can go out back to back.
  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic first);
    logic restart;
    restart = first;
    // An autokey read must never land on a ring entry that was never written.
    if (cur_mode[MODE_AUTO_BIT] && !first_pass && !ring_written[key_pos] && !first)
      restart = 1'b1;
    in_valid            <= 1'b1;
    in_byte             <= value;
    in_first_of_message <= restart;
    do @(posedge clk); while (!in_ready);
    expected_bytes.push_back('{predict_cipher_byte(value, restart), bytes_sent});
    bytes_sent++;
    if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // One phase: random registers, then random messages under that setting.
  task automatic run_phase(input int n_bytes, input bit pause_midway);
    logic [KEY_BITS-1:0] key;
    logic [5:0]          klen;
    logic                first;
    int                  msg_left;
    bit                  fresh;
    case ($urandom_range(0, 9))
      0:       klen = 6'd0;
      1:       klen = 6'd1;
      2:       klen = 6'(KEY_MAX);
      3:       klen = 6'($urandom_range(KEY_MAX + 1, 63));
      4, 5, 6: klen = 6'($urandom_range(2, 8));
      default: klen = 6'($urandom_range(2, KEY_MAX));
    endcase
    case ($urandom_range(0, 5))
      0:       key = '0;
      1:       key = '1;
      default: for (int w = 0; w < KEY_BITS / 32; w++) key[w*32 +: 32] = $urandom();
    endcase
    configure(2'($urandom_range(0, 3)), klen, key,
              NUM_REGS'($urandom_range(0, (1 << NUM_REGS) - 1)));
    sender_gaps = ($urandom_range(0, 3) != 0);
    // Sometimes the message carries on across the register change.
    fresh    = ($urandom_range(0, 3) != 0);
    msg_left = 0;
    for (int i = 0; i < n_bytes; i++) begin
      first = 1'b0;
      if (msg_left == 0) begin
        msg_left = $urandom_range(1, 64);
        first    = (i != 0) || fresh;
      end
      // A little noise on the restart flag.
      if ($urandom_range(0, 19) == 0) first = 1'($urandom_range(0, 1));
      msg_left--;
      if (pause_midway && i == n_bytes / 2) drain_results();
      send_byte(8'($urandom_range(0, 255)), first);
    end
  endtask

  // Registers at their reset values: mode 0, length 1, zero key.
  task automatic test_reset_values();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  // Repeating key with a zero length and a length above the store size.
  task automatic test_repeating_key();
    logic [KEY_BITS-1:0] key;
    key = {8'h80, {(KEY_MAX - 2) * BYTE_W{1'b0}}, 8'hFF};
    configure(MODE_ENC_REPEAT, 6'd0, key, '1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    configure(MODE_DEC_REPEAT, 6'd63, key, 6'b000011);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
  endtask

  // Autokey in both directions, crossing from the key into the plaintext stream.
  task automatic test_autokey();
    logic [KEY_BITS-1:0] key;
    key = {{(KEY_MAX - 3) * BYTE_W{1'b0}}, 24'hF0_20_10};
    configure(MODE_ENC_AUTO, 6'd3, key, '1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);
    send_byte(8'h07, 1'b1);
    configure(MODE_DEC_AUTO, 6'd2, key, 6'b000011);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // Random settings and messages with idling on both sides.
  task automatic test_random_messages();
    int stop_at;
    int phase;
    stop_at = bytes_sent + RANDOM_BYTES;
    phase   = 0;
    while (bytes_sent < stop_at) begin
      run_phase($urandom_range(20, 120), phase == 2);
      phase++;
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_back_to_back();
    quiet_tail = 1'b1;
    run_phase(80, 1'b0);
    run_phase(80, 1'b0);
  endtask

  // Output stalls: random bursts of backpressure between ready stretches.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (quiet_tail) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Compares each output beat with the oldest prediction.
  always @(posedge clk) begin
    cipher_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected output beat: out_byte=%02h", out_byte);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.value) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("byte %0d: out_byte expected %02h, got %02h",
                     want.seq, want.value, out_byte);
        end
      end
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n               <= 1'b0;
    cfg_valid           <= 1'b0;
    cfg_index           <= CFG_MODE;
    cfg_data            <= '0;
    in_valid            <= 1'b0;
    in_byte             <= '0;
    in_first_of_message <= 1'b0;
    cur_mode       = MODE_ENC_REPEAT;
    cur_key_length = 6'd1;
    cur_key        = '0;
    key_pos        = '0;
    first_pass     = 1'b1;
    for (int i = 0; i < KEY_MAX; i++) ring_written[i] = 1'b0;
    bytes_sent     = 0;
    mismatch_count = 0;
    sender_gaps    = 1'b1;
    quiet_tail     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_repeating_key();
    test_autokey();
    test_random_messages();
    test_back_to_back();
    drain_results();

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("** byte_vigenere_autokey_cipher: PASSED **");
    end else begin
      $display("** byte_vigenere_autokey_cipher: FAILED **");
    end
    $finish;
  end

endmodule
